// ===== sv/imq_pkg.sv =====
// Shared types, constants and codes for the indexed max priority queue.
package imq_pkg;

    localparam int ID_COUNT_DEF = 256;
    localparam int KEY_BITS_DEF = 32;

    localparam logic [2:0] OP_INSERT   = 3'd0;
    localparam logic [2:0] OP_DELETE   = 3'd1;
    localparam logic [2:0] OP_CONTAINS = 3'd2;
    localparam logic [2:0] OP_GET_MAX  = 3'd3;
    localparam logic [2:0] OP_RESET    = 3'd4;

    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_RANGE     = 3'd1;
    localparam logic [2:0] STS_PRESENT   = 3'd2;
    localparam logic [2:0] STS_FULL      = 3'd3;
    localparam logic [2:0] STS_ABSENT    = 3'd4;
    localparam logic [2:0] STS_EMPTY     = 3'd5;

    localparam logic [1:0] REG_MAX_ID = 2'd0;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_DEL_HOLE,
        S_DEL_LAST,
        S_UP_READ,
        S_UP_CMP,
        S_DN_READL,
        S_DN_CMPL,
        S_DN_CMPR,
        S_DONE
    } imq_state_t;

    typedef struct packed {
        logic [2:0] status;
        logic       is_present;
    } imq_flags_t;

endpackage

// ===== sv/imq_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module imq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/imq_ctrl.sv =====
// Heap sequencer: lookups, sift-up and sift-down over the slot and position memories.
module imq_ctrl
    import imq_pkg::*;
#(
    parameter int ID_COUNT = ID_COUNT_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF,
    localparam int ID_W = $clog2(ID_COUNT)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_operation,
    input  logic [ID_W-1:0]     s_entry_id,
    input  logic [KEY_BITS-1:0] s_entry_key,
    input  logic [ID_W-1:0]     max_id,
    output logic                res_valid,
    input  logic                res_ready,
    output imq_flags_t          res_flags,
    output logic [ID_W-1:0]     res_top_id,
    output logic [KEY_BITS-1:0] res_top_key,
    output logic [ID_W-1:0]     res_count
);

    localparam int HW = ID_W + KEY_BITS;
    localparam logic [ID_W-1:0] ID_LAST = ID_W'(ID_COUNT - 1);

    imq_state_t state_reg, state_next;

    logic [2:0]          op_reg, op_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [ID_W-1:0]     fill_reg, fill_next;
    logic [ID_W-1:0]     hole_reg, hole_next;
    logic [ID_W-1:0]     mv_id_reg, mv_id_next;
    logic [KEY_BITS-1:0] mv_key_reg, mv_key_next;
    logic [KEY_BITS-1:0] gone_key_reg, gone_key_next;
    logic [ID_W-1:0]     l_id_reg, l_id_next;
    logic [KEY_BITS-1:0] l_key_reg, l_key_next;
    logic [ID_W-1:0]     clr_reg, clr_next;
    logic                clr_res_reg, clr_res_next;
    logic [ID_W-1:0]     root_id_reg;
    logic [KEY_BITS-1:0] root_key_reg;
    imq_flags_t          flags_reg, flags_next;

    logic            heap_we;
    logic [ID_W-1:0] heap_wa, heap_ra;
    logic [HW-1:0]   heap_wd, heap_rd;
    logic            pos_we;
    logic [ID_W-1:0] pos_wa, pos_wd, pos_rd;

    logic [ID_W-1:0]     rd_id;
    logic [KEY_BITS-1:0] rd_key;
    logic                in_range, ins_ok, del_ok;
    logic [ID_W:0]       child_l, child_r;
    logic                has_l, has_r, up_beats, l_beats, r_beats, pick_l, pick_r;
    logic [ID_W-1:0]     parent;

    imq_ram #(.WIDTH(HW), .DEPTH(ID_COUNT)) u_heap_ram (
        .aclk   (aclk),
        .wr_en  (heap_we),
        .wr_addr(heap_wa),
        .wr_data(heap_wd),
        .rd_addr(heap_ra),
        .rd_data(heap_rd)
    );

    imq_ram #(.WIDTH(ID_W), .DEPTH(ID_COUNT)) u_pos_ram (
        .aclk   (aclk),
        .wr_en  (pos_we),
        .wr_addr(pos_wa),
        .wr_data(pos_wd),
        .rd_addr(s_entry_id),
        .rd_data(pos_rd)
    );

    assign rd_id    = heap_rd[HW-1:KEY_BITS];
    assign rd_key   = heap_rd[KEY_BITS-1:0];
    assign in_range = (id_reg <= max_id) && (id_reg <= ID_LAST);
    assign ins_ok   = in_range && (pos_rd == '0) && (fill_reg < max_id)
                      && (fill_reg < ID_LAST);
    assign del_ok   = in_range && (pos_rd != '0) && (pos_rd <= fill_reg);
    assign child_l  = {hole_reg, 1'b0};
    assign child_r  = {hole_reg, 1'b1};
    assign has_l    = child_l <= {1'b0, fill_reg};
    assign has_r    = child_r <= {1'b0, fill_reg};
    assign parent   = {1'b0, hole_reg[ID_W-1:1]};
    assign up_beats = mv_key_reg > rd_key;
    assign l_beats  = l_key_reg > mv_key_reg;
    assign r_beats  = rd_key > mv_key_reg;
    // Right child wins a tie between two children that both beat the parent.
    assign pick_l   = l_beats && (!r_beats || (l_key_reg > rd_key));
    assign pick_r   = r_beats && !pick_l;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (clr_reg == ID_LAST) begin
                    state_next = clr_res_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                case (op_reg)
                    OP_INSERT: state_next = ins_ok ? S_UP_READ : S_DONE;
                    OP_DELETE: state_next = del_ok ? S_DEL_HOLE : S_DONE;
                    OP_RESET:  state_next = S_CLEAR;
                    default:   state_next = S_DONE;
                endcase
            end
            S_DEL_HOLE: state_next = S_DEL_LAST;
            S_DEL_LAST: begin
                if (hole_reg == fill_reg) begin
                    state_next = S_DONE;
                end else if (rd_key > gone_key_reg) begin
                    state_next = S_UP_READ;
                end else begin
                    state_next = S_DN_READL;
                end
            end
            S_UP_READ: state_next = (hole_reg > ID_W'(1)) ? S_UP_CMP : S_DONE;
            S_UP_CMP:  state_next = up_beats ? S_UP_READ : S_DONE;
            S_DN_READL: state_next = has_l ? S_DN_CMPL : S_DONE;
            S_DN_CMPL: begin
                if (has_r) begin
                    state_next = S_DN_CMPR;
                end else if (rd_key > mv_key_reg) begin
                    state_next = S_DN_READL;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DN_CMPR: state_next = (pick_l || pick_r) ? S_DN_READL : S_DONE;
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        op_next       = op_reg;
        id_next       = id_reg;
        key_next      = key_reg;
        fill_next     = fill_reg;
        hole_next     = hole_reg;
        mv_id_next    = mv_id_reg;
        mv_key_next   = mv_key_reg;
        gone_key_next = gone_key_reg;
        l_id_next     = l_id_reg;
        l_key_next    = l_key_reg;
        clr_next      = clr_reg;
        clr_res_next  = clr_res_reg;
        flags_next    = flags_reg;
        heap_we       = 1'b0;
        heap_wa       = hole_reg;
        heap_wd       = {mv_id_reg, mv_key_reg};
        heap_ra       = hole_reg;
        pos_we        = 1'b0;
        pos_wa        = mv_id_reg;
        pos_wd        = hole_reg;
        s_ready       = 1'b0;
        res_valid     = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                pos_we   = 1'b1;
                pos_wa   = clr_reg;
                pos_wd   = '0;
                clr_next = clr_reg + ID_W'(1);
                if (clr_reg == ID_LAST) begin
                    clr_res_next = 1'b0;
                end
            end
            S_IDLE: begin
                s_ready  = 1'b1;
                op_next  = s_operation;
                id_next  = s_entry_id;
                key_next = s_entry_key;
            end
            S_LOOKUP: begin
                flags_next.status     = STS_OK;
                flags_next.is_present = 1'b0;
                case (op_reg)
                    OP_INSERT: begin
                        if (!in_range) begin
                            flags_next.status = STS_RANGE;
                        end else if (pos_rd != '0) begin
                            flags_next.status = STS_PRESENT;
                        end else if (!ins_ok) begin
                            flags_next.status = STS_FULL;
                        end else begin
                            fill_next   = fill_reg + ID_W'(1);
                            hole_next   = fill_reg + ID_W'(1);
                            mv_id_next  = id_reg;
                            mv_key_next = key_reg;
                        end
                    end
                    OP_DELETE: begin
                        if (!in_range) begin
                            flags_next.status = STS_RANGE;
                        end else if (!del_ok) begin
                            flags_next.status = STS_ABSENT;
                        end else begin
                            hole_next = pos_rd;
                            heap_ra   = pos_rd;
                            pos_we    = 1'b1;
                            pos_wa    = id_reg;
                            pos_wd    = '0;
                        end
                    end
                    OP_CONTAINS: begin
                        if (!in_range) begin
                            flags_next.status = STS_RANGE;
                        end else begin
                            flags_next.is_present = (pos_rd != '0);
                        end
                    end
                    OP_GET_MAX: begin
                        if (fill_reg == '0) begin
                            flags_next.status = STS_EMPTY;
                        end
                    end
                    OP_RESET: begin
                        fill_next    = '0;
                        clr_next     = '0;
                        clr_res_next = 1'b1;
                    end
                    default: begin
                        flags_next.status = STS_OK;
                    end
                endcase
            end
            S_DEL_HOLE: begin
                gone_key_next = rd_key;
                heap_ra       = fill_reg;
            end
            S_DEL_LAST: begin
                fill_next   = fill_reg - ID_W'(1);
                mv_id_next  = rd_id;
                mv_key_next = rd_key;
            end
            S_UP_READ: begin
                if (hole_reg > ID_W'(1)) begin
                    heap_ra = parent;
                end else begin
                    heap_we = 1'b1;
                    pos_we  = 1'b1;
                end
            end
            S_UP_CMP: begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
                if (up_beats) begin
                    heap_wd   = heap_rd;
                    pos_wa    = rd_id;
                    hole_next = parent;
                end
            end
            S_DN_READL: begin
                if (has_l) begin
                    heap_ra = child_l[ID_W-1:0];
                end else begin
                    heap_we = 1'b1;
                    pos_we  = 1'b1;
                end
            end
            S_DN_CMPL: begin
                l_id_next  = rd_id;
                l_key_next = rd_key;
                if (has_r) begin
                    heap_ra = child_r[ID_W-1:0];
                end else begin
                    heap_we = 1'b1;
                    pos_we  = 1'b1;
                    if (rd_key > mv_key_reg) begin
                        heap_wd   = heap_rd;
                        pos_wa    = rd_id;
                        hole_next = child_l[ID_W-1:0];
                    end
                end
            end
            S_DN_CMPR: begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
                if (pick_l) begin
                    heap_wd   = {l_id_reg, l_key_reg};
                    pos_wa    = l_id_reg;
                    hole_next = child_l[ID_W-1:0];
                end else if (pick_r) begin
                    heap_wd   = heap_rd;
                    pos_wa    = rd_id;
                    hole_next = child_r[ID_W-1:0];
                end
            end
            S_DONE: begin
                res_valid = 1'b1;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            fill_reg    <= '0;
            clr_reg     <= '0;
            clr_res_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            clr_reg     <= clr_next;
            clr_res_reg <= clr_res_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        id_reg       <= id_next;
        key_reg      <= key_next;
        hole_reg     <= hole_next;
        mv_id_reg    <= mv_id_next;
        mv_key_reg   <= mv_key_next;
        gone_key_reg <= gone_key_next;
        l_id_reg     <= l_id_next;
        l_key_reg    <= l_key_next;
        flags_reg    <= flags_next;
        if (heap_we && (heap_wa == ID_W'(1))) begin
            root_id_reg  <= heap_wd[HW-1:KEY_BITS];
            root_key_reg <= heap_wd[KEY_BITS-1:0];
        end
    end

    assign res_flags   = flags_reg;
    assign res_count   = fill_reg;
    assign res_top_id  = (fill_reg == '0) ? '0 : root_id_reg;
    assign res_top_key = (fill_reg == '0) ? '0 : root_key_reg;

    a_no_write_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        heap_we |-> (heap_wa != '0))
        else $error("heap write to slot zero");

    a_fill_changes_only_in_update: assert property (@(posedge aclk) disable iff (!aresetn)
        !(state_reg == S_LOOKUP || state_reg == S_DEL_LAST) |=> $stable(fill_reg))
        else $error("fill count changed outside an update step");

    a_no_write_while_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE || state_reg == S_IDLE) |-> !(heap_we || pos_we))
        else $error("memory written while not working on a request");

endmodule

// ===== sv/indexed_max_priority_queue.sv =====
// Top level of the indexed max priority queue: register port, sequencer and result register.
// A request carries an operation (insert, delete by identifier, contains, get maximum,
// reset), an identifier and a key; each request yields exactly one result with a status,
// the contains answer, the identifier and key at the root and the entry count. The heap
// lives in two synchronous memories: one holds identifier and key by heap slot, the other
// the heap slot of each identifier (zero means absent). An insert looks up the identifier,
// then climbs the new entry level by level; a delete looks up the identifier, reads the
// freed slot and the last slot, then sifts the last entry up or down from the hole. The
// rate is set by the one read port of the slot memory: each level of a sift reads it once
// or twice and the read data is registered. After reset release and after a reset request
// the position memory is swept clear, one entry per cycle; no request is taken during
// that sweep, and the result of a reset request appears when it ends. A finished result
// sits in an output register, so the next request is taken while the result waits.
// max_id must be written over the register port only while the block is idle; the block
// itself does not enforce this. Lowering it below the entry count keeps the entries and
// makes further inserts report full.
module indexed_max_priority_queue
    import imq_pkg::*;
#(
    parameter int ID_COUNT = ID_COUNT_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF,
    localparam int ID_W = $clog2(ID_COUNT)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_operation,
    input  logic [ID_W-1:0]     s_entry_id,
    input  logic [KEY_BITS-1:0] s_entry_key,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_status,
    output logic                m_is_present,
    output logic [ID_W-1:0]     m_top_id,
    output logic [KEY_BITS-1:0] m_top_key,
    output logic [ID_W-1:0]     m_entry_count
);

    logic [ID_W-1:0]     max_id_reg;
    logic                res_valid, res_ready;
    imq_flags_t          res_flags;
    logic [ID_W-1:0]     res_top_id, res_count;
    logic [KEY_BITS-1:0] res_top_key;

    logic                out_valid_reg;
    imq_flags_t          out_flags_reg;
    logic [ID_W-1:0]     out_top_id_reg, out_count_reg;
    logic [KEY_BITS-1:0] out_top_key_reg;

    // The register port never stalls; only the word at offset zero holds max_id.
    assign pready = 1'b1;
    assign prdata = (paddr == REG_MAX_ID) ? {{(32 - ID_W){1'b0}}, max_id_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_id_reg <= ID_W'(ID_COUNT - 1);
        end else if (psel && penable && pwrite && pready && (paddr == REG_MAX_ID)) begin
            max_id_reg <= pwdata[ID_W-1:0];
        end
    end

    imq_ctrl #(
        .ID_COUNT(ID_COUNT),
        .KEY_BITS(KEY_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_operation(s_operation),
        .s_entry_id (s_entry_id),
        .s_entry_key(s_entry_key),
        .max_id     (max_id_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_flags  (res_flags),
        .res_top_id (res_top_id),
        .res_top_key(res_top_key),
        .res_count  (res_count)
    );

    // The output register frees the sequencer as soon as a result is captured.
    assign res_ready = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_flags_reg   <= res_flags;
            out_top_id_reg  <= res_top_id;
            out_top_key_reg <= res_top_key;
            out_count_reg   <= res_count;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = out_flags_reg.status;
    assign m_is_present  = out_flags_reg.is_present;
    assign m_top_id      = out_top_id_reg;
    assign m_top_key     = out_top_key_reg;
    assign m_entry_count = out_count_reg;

endmodule

// ===== tb/tb_indexed_max_priority_queue.sv =====
// Self-checking testbench for the indexed max priority queue: heap predictor, request driver, result checker.
module tb_indexed_max_priority_queue;
    import imq_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_operation = '0;
    logic [7:0]  s_entry_id = '0;
    logic [31:0] s_entry_key = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic        m_is_present;
    logic [7:0]  m_top_id;
    logic [31:0] m_top_key;
    logic [7:0]  m_entry_count;

    always #1 aclk = ~aclk;

    indexed_max_priority_queue dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_entry_id(s_entry_id), .s_entry_key(s_entry_key),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_is_present(m_is_present), .m_top_id(m_top_id), .m_top_key(m_top_key),
        .m_entry_count(m_entry_count)
    );

    // One expected result of a request.
    typedef struct packed {
        logic [2:0]  status;
        logic        is_present;
        logic [7:0]  top_id;
        logic [31:0] top_key;
        logic [7:0]  entry_count;
    } heap_answer_t;

    // Predictor state: a mirror of the heap, its position map and the key of every id.
    logic [7:0]  pm_max_id;
    logic [7:0]  pm_heap [0:255];
    logic [7:0]  pm_pos [0:255];
    logic [31:0] pm_key [0:255];
    int unsigned pm_fill;

    heap_answer_t answers_due[$];
    bit           failed = 1'b0;
    int           rx_wait = 0;

    function automatic logic [31:0] slot_key(int unsigned slot);
        return pm_key[pm_heap[slot]];
    endfunction

    function automatic void put_slot(logic [7:0] id, int unsigned slot);
        pm_heap[slot] = id;
        pm_pos[id] = slot[7:0];
    endfunction

    function automatic void swap_slot(int unsigned a, int unsigned b);
        logic [7:0] ida;
        ida = pm_heap[a];
        put_slot(pm_heap[b], a);
        put_slot(ida, b);
    endfunction

    function automatic void climb(int unsigned slot);
        while (slot >= 2 && slot_key(slot) > slot_key(slot / 2)) begin
            swap_slot(slot, slot / 2);
            slot = slot / 2;
        end
    endfunction

    // Sift down; when both children beat the parent with equal keys the right one wins.
    function automatic void sink(int unsigned slot);
        int unsigned l, r, pick;
        bit lw, rw;
        while (slot * 2 + 1 <= pm_fill) begin
            l = slot * 2;
            r = l + 1;
            lw = slot_key(l) > slot_key(slot);
            rw = slot_key(r) > slot_key(slot);
            if (lw && rw) pick = (slot_key(l) > slot_key(r)) ? l : r;
            else if (lw) pick = l;
            else if (rw) pick = r;
            else return;
            swap_slot(pick, slot);
            slot = pick;
        end
        if (slot * 2 <= pm_fill && slot_key(slot * 2) > slot_key(slot))
            swap_slot(slot * 2, slot);
    endfunction

    function automatic void clear_heap();
        for (int i = 0; i < 256; i++) pm_pos[i] = '0;
        pm_fill = 0;
    endfunction

    function automatic heap_answer_t predict_heap_op(logic [2:0] op, logic [7:0] id,
                                                     logic [31:0] key);
        heap_answer_t a;
        int unsigned hole, last;
        logic [31:0] gone, moved;
        a = '0;
        case (op)
            OP_INSERT: begin
                if (id > pm_max_id) a.status = STS_RANGE;
                else if (pm_pos[id] != 0) a.status = STS_PRESENT;
                else if (pm_fill >= pm_max_id) a.status = STS_FULL;
                else begin
                    pm_key[id] = key;
                    pm_fill++;
                    put_slot(id, pm_fill);
                    climb(pm_fill);
                end
            end
            OP_DELETE: begin
                if (id > pm_max_id) a.status = STS_RANGE;
                else if (pm_pos[id] == 0 || pm_pos[id] > pm_fill) a.status = STS_ABSENT;
                else begin
                    hole = pm_pos[id];
                    last = pm_fill;
                    gone = pm_key[id];
                    pm_pos[id] = '0;
                    pm_fill--;
                    if (hole != last) begin
                        moved = slot_key(last);
                        put_slot(pm_heap[last], hole);
                        if (moved > gone) climb(hole);
                        else sink(hole);
                    end
                end
            end
            OP_CONTAINS: begin
                if (id > pm_max_id) a.status = STS_RANGE;
                else a.is_present = pm_pos[id] != 0;
            end
            OP_GET_MAX: if (pm_fill == 0) a.status = STS_EMPTY;
            OP_RESET: clear_heap();
            default: ;
        endcase
        if (pm_fill > 0) begin
            a.top_id = pm_heap[1];
            a.top_key = slot_key(1);
        end
        a.entry_count = pm_fill[7:0];
        return a;
    endfunction

    // Sends one request after a random gap and queues its expected result.
    // Valid stays high after an accept so that a request with no gap follows at once;
    // it drops only when a gap is drawn or the traffic drains.
    task automatic send_request(logic [2:0] op, logic [7:0] id, logic [31:0] key);
        int gap;
        gap = (($urandom & 3) == 0) ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_entry_id <= id;
        s_entry_key <= key;
        do @(posedge aclk); while (!s_ready);
        answers_due.push_back(predict_heap_op(op, id, key));
    endtask

    // Drops valid and waits until every result is back, plus a short margin.
    task automatic drain();
        s_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_max_id(logic [7:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= REG_MAX_ID; pwdata <= {24'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        pm_max_id = value;
    endtask

    // The receiver draws for each result how many cycles it waits before taking it.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                rx_wait = $urandom_range(0, 15);
                m_ready <= (rx_wait == 0);
            end else if (!m_ready) begin
                if (rx_wait > 0) rx_wait--;
                if (rx_wait == 0) m_ready <= 1'b1;
            end
        end
    end

    // Checks each accepted result against the oldest expected one.
    always @(posedge aclk) begin
        heap_answer_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (answers_due.size() == 0) begin
                $display("%0t: unexpected result status=%0d", $time, m_status);
                failed = 1'b1;
            end else begin
                exp_r = answers_due.pop_front();
                if (m_status !== exp_r.status) begin
                    $display("%0t: status exp %0d got %0d", $time, exp_r.status, m_status);
                    failed = 1'b1;
                end
                if (m_is_present !== exp_r.is_present) begin
                    $display("%0t: is_present exp %0d got %0d", $time, exp_r.is_present,
                             m_is_present);
                    failed = 1'b1;
                end
                if (m_top_id !== exp_r.top_id) begin
                    $display("%0t: top_id exp %0d got %0d", $time, exp_r.top_id, m_top_id);
                    failed = 1'b1;
                end
                if (m_top_key !== exp_r.top_key) begin
                    $display("%0t: top_key exp %h got %h", $time, exp_r.top_key, m_top_key);
                    failed = 1'b1;
                end
                if (m_entry_count !== exp_r.entry_count) begin
                    $display("%0t: entry_count exp %0d got %0d", $time, exp_r.entry_count,
                             m_entry_count);
                    failed = 1'b1;
                end
            end
        end
    end

    // Field extremes, every operation, and the empty, absent and present statuses.
    task automatic test_directed();
        send_request(OP_GET_MAX, 8'd0, 32'd0);
        send_request(OP_DELETE, 8'd5, 32'd0);
        send_request(OP_INSERT, 8'd255, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 8'd0, 32'd0);
        send_request(OP_INSERT, 8'd0, 32'd7);
        send_request(OP_INSERT, 8'd10, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 8'd11, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 8'd12, 32'hAAAA_5555);
        send_request(OP_CONTAINS, 8'd11, 32'd0);
        send_request(OP_CONTAINS, 8'd200, 32'd0);
        send_request(OP_DELETE, 8'd255, 32'd0);
        send_request(OP_DELETE, 8'd0, 32'd0);
        send_request(3'd5, 8'd1, 32'd1);
        send_request(3'd7, 8'd2, 32'd2);
        send_request(OP_GET_MAX, 8'd0, 32'd0);
        send_request(OP_RESET, 8'd0, 32'd0);
        send_request(OP_CONTAINS, 8'd11, 32'd0);
        drain();
    endtask

    // A small register: range errors, full heap, then lowering below the fill count.
    task automatic test_small_capacity();
        write_max_id(8'd1);
        send_request(OP_INSERT, 8'd2, 32'd9);
        send_request(OP_INSERT, 8'd1, 32'd9);
        send_request(OP_INSERT, 8'd0, 32'd3);
        send_request(OP_DELETE, 8'd1, 32'd0);
        send_request(OP_INSERT, 8'd0, 32'd3);
        drain();
        write_max_id(8'd8);
        for (int i = 1; i <= 8; i++) send_request(OP_INSERT, i[7:0], $urandom & 32'hF);
        send_request(OP_INSERT, 8'd0, 32'd5);
        drain();
        write_max_id(8'd3);
        send_request(OP_INSERT, 8'd0, 32'd1);
        send_request(OP_DELETE, 8'd7, 32'd0);
        send_request(OP_DELETE, 8'd2, 32'd0);
        send_request(OP_GET_MAX, 8'd0, 32'd0);
        send_request(OP_RESET, 8'd0, 32'd0);
        drain();
    endtask

    // Random traffic: mostly inserts and deletes of ids in range, keys from narrow or full ranges.
    task automatic test_random(int count, logic [7:0] cap);
        int pick;
        logic [2:0] op;
        logic [7:0] id;
        logic [31:0] key;
        write_max_id(cap);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) op = OP_INSERT;
            else if (pick < 75) op = OP_DELETE;
            else if (pick < 87) op = OP_CONTAINS;
            else if (pick < 95) op = OP_GET_MAX;
            else if (pick < 97) op = OP_RESET;
            else op = 3'($urandom_range(5, 7));
            id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, cap));
            key = ($urandom & 1) ? ($urandom & 32'h7) : $urandom;
            send_request(op, id, key);
        end
        drain();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        pm_max_id = 8'd255;
        clear_heap();
        test_directed();
        test_small_capacity();
        test_random(200, 8'd15);
        test_random(250, 8'd255);
        test_random(120, 8'd40);
        if (!failed && answers_due.size() == 0) begin
            $display("indexed_max_priority_queue test passed");
        end else begin
            $display("indexed_max_priority_queue test failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("indexed_max_priority_queue test failed");
        $finish;
    end

endmodule

// ===== files.f =====
sv/imq_pkg.sv
sv/imq_ram.sv
sv/imq_ctrl.sv
sv/indexed_max_priority_queue.sv
tb/tb_indexed_max_priority_queue.sv
